// File: src/tpd_pkg.sv
// shared types and constants for the tile pattern dedup block
package tpd_pkg;

    localparam int MAX_GLYPHS  = 96;
    localparam int TILE_WIDTH  = 6;
    localparam int TILE_HEIGHT = 8;

    localparam int TILE_BITS_W = 48;
    localparam int OUT_W       = 7;
    localparam int CHAR_BASE   = 32;

    localparam int PIX_W = TILE_WIDTH * TILE_HEIGHT;
    localparam int PAT_W = (PIX_W < TILE_BITS_W) ? PIX_W : TILE_BITS_W;
    localparam int IDX_W = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
    localparam int CNT_W = $clog2(MAX_GLYPHS + 1);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SEARCH
    } t_state;

    typedef struct packed {
        logic load;
        logic issue;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic issue_done;
        logic hit;
    } t_sts;

endpackage

// File: src/tpd_ram.sv
// generic single-port-write, registered-read ram
module tpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/tpd_ctrl.sv
// controller state machine for the pattern search
module tpd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  tpd_pkg::t_sts i_sts,
    output tpd_pkg::t_cmd o_cmd,
    output logic          o_busy
);
    import tpd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.issue  = 1'b0;
        o_cmd.finish = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (i_sts.hit || i_sts.issue_done) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end else begin
                    o_cmd.issue = 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

// File: src/tpd_dp.sv
// datapath: pattern table, search pointer, compare and result registers
module tpd_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [tpd_pkg::TILE_BITS_W-1:0]  i_tile_bits,
    input  logic                             i_first_tile,
    input  tpd_pkg::t_cmd                    i_cmd,
    output tpd_pkg::t_sts                    o_sts,
    output logic                             o_valid,
    output logic [tpd_pkg::OUT_W-1:0]        o_char_code,
    output logic                             o_new_glyph,
    output logic [tpd_pkg::OUT_W-1:0]        o_glyph_slot,
    output logic                             o_table_full
);
    import tpd_pkg::*;

    logic [PAT_W-1:0] r_pat;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_rd_ptr;
    logic             r_cmp_vld;
    logic [IDX_W-1:0] r_cmp_idx;
    logic [PAT_W-1:0] rd_data;

    logic             r_valid;
    logic [OUT_W-1:0] r_char_code;
    logic             r_new_glyph;
    logic [OUT_W-1:0] r_glyph_slot;
    logic             r_table_full;

    logic             hit;
    logic             full;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] res_idx;

    assign hit     = r_cmp_vld && (rd_data == r_pat);
    assign full    = (r_count == CNT_W'(MAX_GLYPHS));
    assign wr_en   = i_cmd.finish && !hit && !full;
    assign wr_idx  = r_count[IDX_W-1:0];
    assign res_idx = hit ? r_cmp_idx : (full ? '0 : wr_idx);

    assign o_sts.hit        = hit;
    assign o_sts.issue_done = (r_rd_ptr == r_count);

    tpd_ram #(
        .WIDTH (PAT_W),
        .DEPTH (MAX_GLYPHS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_idx),
        .i_wdata (r_pat),
        .i_re    (i_cmd.issue),
        .i_raddr (r_rd_ptr[IDX_W-1:0]),
        .o_rdata (rd_data)
    );

    // glyph count and compare tag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
            r_count   <= '0;
        end else begin
            r_cmp_vld <= i_cmd.issue;
            if (i_cmd.load && i_first_tile) begin
                r_count <= '0;
            end else if (wr_en) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pat    <= i_tile_bits[PAT_W-1:0];
            r_rd_ptr <= '0;
        end else if (i_cmd.issue) begin
            r_rd_ptr <= r_rd_ptr + CNT_W'(1);
        end
        r_cmp_idx <= r_rd_ptr[IDX_W-1:0];
    end

    // result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_new_glyph  <= !hit && !full;
            r_table_full <= !hit && full;
            r_glyph_slot <= OUT_W'(res_idx);
            r_char_code  <= (!hit && full) ? OUT_W'(CHAR_BASE)
                                           : OUT_W'(CHAR_BASE) + OUT_W'(res_idx);
        end
    end

    assign o_valid      = r_valid;
    assign o_char_code  = r_char_code;
    assign o_new_glyph  = r_new_glyph;
    assign o_glyph_slot = r_glyph_slot;
    assign o_table_full = r_table_full;

endmodule

// File: src/tile_pattern_dedup_charmap.sv
// top level of the tile pattern dedup character map builder
//
// channel   ports                                           handshake
// input     i_tile_bits, i_first_tile                       start & !busy
// result    o_char_code, o_new_glyph, o_glyph_slot,         o_valid, one cycle
//           o_table_full
//
// the table is searched one stored slot per cycle through the ram read port
// a tile that hits slot k ends the search at the compare of slot k
// a new or full-table tile with n slots in use is compared against all n slots
// the result beat is out in the first cycle with busy low; the receiver cannot stall
// synchronous reset empties the table; no clearing pass is needed
module tile_pattern_dedup_charmap (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [tpd_pkg::TILE_BITS_W-1:0]  i_tile_bits,
    input  logic                             i_first_tile,
    output logic                             o_valid,
    output logic [tpd_pkg::OUT_W-1:0]        o_char_code,
    output logic                             o_new_glyph,
    output logic [tpd_pkg::OUT_W-1:0]        o_glyph_slot,
    output logic                             o_table_full
);
    import tpd_pkg::*;

    t_cmd cmd;
    t_sts sts;

    tpd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    tpd_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tile_bits  (i_tile_bits),
        .i_first_tile (i_first_tile),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_valid      (o_valid),
        .o_char_code  (o_char_code),
        .o_new_glyph  (o_new_glyph),
        .o_glyph_slot (o_glyph_slot),
        .o_table_full (o_table_full)
    );

endmodule
